FILE: design/stbs_pkg.sv
// shared types and constants for the sorted table binary search block
// no dependencies; imported by stbs_step and the top level of the block

package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ENTRY_WIDTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int RES_W       = 11;
  localparam int CFG_W       = 11;

  // input word action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // search mode codes
  localparam logic MODE_LOWER = 1'b0;
  localparam logic MODE_FLOOR = 1'b1;

  // configuration register indexes
  localparam logic CFG_SEARCH_FIRST = 1'b0;
  localparam logic CFG_SEARCH_LAST  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_PROBE,
    ST_FINAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                          probe;
    logic                          mode;
    logic [RES_W-1:0]              lo;
    logic [RES_W-1:0]              hi;
    logic [RES_W-1:0]              mid;
    logic signed [ENTRY_WIDTH-1:0] rdata;
    logic signed [ENTRY_WIDTH-1:0] key;
  } step_in_t;

  typedef struct packed {
    logic             found;
    logic             go_probe;
    logic             go_final;
    logic [RES_W-1:0] lo;
    logic [RES_W-1:0] hi;
    logic [RES_W-1:0] mid;
  } step_out_t;

endpackage

FILE: design/stbs_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no package dependencies

module stbs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/stbs_step.sv
// shared compare and bound update unit, one probe per use
// depends on stbs_pkg

module stbs_step (
  input  stbs_pkg::step_in_t  si,
  output stbs_pkg::step_out_t so
);
  import stbs_pkg::*;

  logic [RES_W-1:0] lo;
  logic [RES_W-1:0] hi;
  logic [RES_W-1:0] span;
  logic             found;
  logic             nonempty;

  always_comb begin
    lo    = si.lo;
    hi    = si.hi;
    found = 1'b0;
    if (si.probe) begin
      if (si.rdata == si.key) begin
        lo    = si.mid;
        found = 1'b1;
      end else if (si.rdata > si.key) begin
        hi = (si.mode == MODE_FLOOR) ? si.mid - RES_W'(1) : si.mid;
      end else begin
        lo = (si.mode == MODE_FLOOR) ? si.mid : si.mid + RES_W'(1);
      end
    end
    nonempty = lo < hi;
    // floor mode rounds the midpoint up
    span     = hi - lo + ((si.mode == MODE_FLOOR) ? RES_W'(1) : RES_W'(0));
    so.found    = found;
    so.lo       = lo;
    so.hi       = hi;
    so.mid      = lo + (span >> 1);
    so.go_probe = !found && nonempty;
    so.go_final = !found && !nonempty && (si.mode == MODE_FLOOR) && (lo == hi);
  end

endmodule

FILE: design/sorted_table_binary_search_top.sv
// top level of the sorted table binary search block
// depends on stbs_pkg, stbs_ram and stbs_step

// A write word stores one table entry. A search word passes from its
// acceptance to its result in the output register through a setup step
// that forms the first midpoint (the range is clamped as the word is
// accepted), P probe steps, a closing compare in floor mode when the range
// closes on a single entry that is still compared, and a step that loads
// the output register. P is at most ceil(log2(n + 1)) for a range of n
// entries, 11 for the full table. The search is paced by the table memory,
// whose one read port returns one registered entry per cycle, feeding the
// single compare and bound unit. The input is stalled while a search runs;
// a finished result waits in the output register while out_stall is high,
// and the next word is accepted as soon as it is loaded.
// The user must see that search_first and search_last are written only
// while the block is idle; the block itself does not enforce this.
// Table entries must be written before a search can probe them.

module sorted_table_binary_search_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // configuration port
  input  logic                                    cfg_we,
  input  logic                                    cfg_index,
  input  logic [stbs_pkg::CFG_W-1:0]              cfg_wdata,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_action,
  input  logic [stbs_pkg::IDX_W-1:0]              in_entry_index,
  input  logic signed [stbs_pkg::ENTRY_WIDTH-1:0] in_value,
  input  logic                                    in_search_mode,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [stbs_pkg::RES_W-1:0]              out_result_index,
  output logic                                    out_found
);
  import stbs_pkg::*;

  // configuration registers
  logic [IDX_W-1:0] search_first_r;
  logic [RES_W-1:0] search_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_first_r <= '0;
      search_last_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEARCH_FIRST: search_first_r <= cfg_wdata[IDX_W-1:0];
        CFG_SEARCH_LAST:  search_last_r  <= cfg_wdata[RES_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state and search registers
  state_t                  state_r, state_nxt;
  logic [RES_W-1:0]        lo_r, lo_nxt;
  logic [RES_W-1:0]        hi_r, hi_nxt;
  logic [RES_W-1:0]        mid_r, mid_nxt;
  logic                    found_r, found_nxt;
  logic                    mode_r, mode_nxt;
  logic signed [ENTRY_WIDTH-1:0] key_r, key_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]        out_index_r, out_index_nxt;
  logic                    out_found_r, out_found_nxt;

  // table memory
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_raddr;
  logic [ENTRY_WIDTH-1:0]  ram_rdata;

  stbs_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (in_entry_index),
    .wr_data (in_value),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // shared compare and bound unit
  step_in_t  step_in;
  step_out_t step_out;

  assign step_in.probe = (state_r == ST_PROBE);
  assign step_in.mode  = mode_r;
  assign step_in.lo    = lo_r;
  assign step_in.hi    = hi_r;
  assign step_in.mid   = mid_r;
  assign step_in.rdata = $signed(ram_rdata);
  assign step_in.key   = key_r;

  stbs_step u_step (
    .si (step_in),
    .so (step_out)
  );

  // next probe address: midpoint, or the closed single entry in floor mode
  assign ram_raddr = step_out.go_final ? step_out.lo[IDX_W-1:0]
                                       : step_out.mid[IDX_W-1:0];

  assign in_stall  = (state_r != ST_IDLE);
  assign ram_we    = in_valid && !in_stall && (in_action == ACT_WRITE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    found_r     <= found_nxt;
    mode_r      <= mode_nxt;
    key_r       <= key_nxt;
    out_index_r <= out_index_nxt;
    out_found_r <= out_found_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    found_nxt     = found_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    out_index_nxt = out_index_r;
    out_found_nxt = out_found_r;
    // a waiting word leaves when the far side takes it
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_action == ACT_SEARCH)) begin
          mode_nxt  = in_search_mode;
          key_nxt   = in_value;
          found_nxt = 1'b0;
          lo_nxt    = {1'b0, search_first_r};
          // clamp the upper bound to the table
          if (in_search_mode == MODE_FLOOR) begin
            hi_nxt = (search_last_r >= RES_W'(TABLE_DEPTH)) ? RES_W'(TABLE_DEPTH - 1)
                                                            : search_last_r;
          end else begin
            hi_nxt = (search_last_r > RES_W'(TABLE_DEPTH)) ? RES_W'(TABLE_DEPTH)
                                                           : search_last_r;
          end
          state_nxt = ST_START;
        end
      end
      ST_START, ST_PROBE: begin
        lo_nxt    = step_out.lo;
        hi_nxt    = step_out.hi;
        mid_nxt   = step_out.mid;
        found_nxt = step_out.found;
        if (step_out.go_probe) begin
          state_nxt = ST_PROBE;
        end else if (step_out.go_final) begin
          state_nxt = ST_FINAL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_FINAL: begin
        found_nxt = ($signed(ram_rdata) == key_r);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_index_nxt = lo_r;
          out_found_nxt = found_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_index_r;
  assign out_found        = out_found_r;

`ifndef SYNTHESIS
  // a probe is only issued for a nonempty range
  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PROBE |-> lo_r < hi_r)
    else $error("probe issued for an empty range");

  // the probed midpoint lies inside the range of its mode
  a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PROBE |->
      (mode_r == MODE_LOWER && mid_r >= lo_r && mid_r < hi_r) ||
      (mode_r == MODE_FLOOR && mid_r > lo_r && mid_r <= hi_r))
    else $error("midpoint outside search range");

  // the closing compare only happens in floor mode on a single entry
  a_final_single: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINAL |-> mode_r == MODE_FLOOR && lo_r == hi_r)
    else $error("closing compare on a range that is not one entry");

  // a new result word only comes out of the done step
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside the done step");
`endif

endmodule

FILE: tb/testbench.sv
// testbench for sorted_table_binary_search_top: loads sorted and unsorted tables, runs
// lower-bound and floor searches under random flow control and checks every result word
// depends on stbs_pkg and the design sources under design/
`timescale 1ns / 1ps

module testbench;
  import stbs_pkg::*;

  localparam int LAST_MAX       = 1024;     // widest value of search_last
  localparam int TOP_BASE       = TABLE_DEPTH - 64; // start of the region loaded up front
  localparam int SETTLE_CYCLES  = 20;       // longer than one full-range search
  localparam int WATCHDOG_LIMIT = 1000;     // cycles with no accepted word
  localparam int RANDOM_WORDS   = 600;
  localparam logic signed [ENTRY_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ENTRY_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic [RES_W-1:0] idx;
    logic             hit;
  } answer_t;

  // mirror of the table and range registers, plus the answers still owed by the block
  class search_tracker;
    logic signed [ENTRY_WIDTH-1:0] entries [TABLE_DEPTH];
    int      first_reg;
    int      last_reg;
    answer_t owed_q[$];
    int      errors;
    int      checked;

    function new();
      foreach (entries[i]) entries[i] = '0;
      first_reg = 0;
      last_reg  = 0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void set_reg(logic idx, int data);
      if (idx == CFG_SEARCH_FIRST) first_reg = data & 10'h3FF;
      else last_reg = data & 11'h7FF;
    endfunction

    function answer_t search(logic signed [ENTRY_WIDTH-1:0] key, logic mode);
      int      lo;
      int      hi;
      int      mid;
      bit      hit;
      answer_t a;
      lo  = first_reg;
      hi  = last_reg;
      hit = 0;
      if (mode == MODE_LOWER) begin
        if (hi > TABLE_DEPTH) hi = TABLE_DEPTH;
        while (lo < hi && !hit) begin
          mid = lo + (hi - lo) / 2;
          if (entries[mid] == key) begin
            lo  = mid;
            hit = 1;
          end else if (entries[mid] > key) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
      end else begin
        if (hi >= TABLE_DEPTH) hi = TABLE_DEPTH - 1;
        while (lo < hi && !hit) begin
          mid = lo + (hi - lo + 1) / 2;
          if (entries[mid] == key) begin
            lo  = mid;
            hit = 1;
          end else if (entries[mid] > key) begin
            hi = mid - 1;
          end else begin
            lo = mid;
          end
        end
        if (!hit && lo == hi && lo < TABLE_DEPTH) hit = (entries[lo] == key);
      end
      a.idx = lo[RES_W-1:0];
      a.hit = hit;
      return a;
    endfunction

    function void note_word(logic act, logic [IDX_W-1:0] idx,
                            logic signed [ENTRY_WIDTH-1:0] val, logic mode);
      if (act == ACT_WRITE) entries[idx] = val;
      else owed_q.push_back(search(val, mode));
    endfunction

    function void check_result(logic [RES_W-1:0] idx, logic hit);
      answer_t a;
      if (owed_q.size() == 0) begin
        $error("result word with no search outstanding: result_index %0d found %0d", idx, hit);
        errors++;
      end else begin
        a = owed_q.pop_front();
        checked++;
        if (idx !== a.idx) begin
          $error("result_index: expected %0d, actual %0d", a.idx, idx);
          errors++;
        end
        if (hit !== a.hit) begin
          $error("found: expected %0d, actual %0d", a.hit, hit);
          errors++;
        end
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic                          cfg_index;
  logic [CFG_W-1:0]              cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_action;
  logic [IDX_W-1:0]              in_entry_index;
  logic signed [ENTRY_WIDTH-1:0] in_value;
  logic                          in_search_mode;
  logic                          out_valid;
  logic                          out_stall;
  logic [RES_W-1:0]              out_result_index;
  logic                          out_found;

  search_tracker sb;

  // sender pacing: bursts of words with random gaps, switched off for some phases
  bit idle_on;
  int burst_left;
  // receiver stall pattern
  int stall_style;
  int stall_left;
  // run statistics
  int writes_sent;
  int searches_sent;
  int settings_used;
  int random_words;
  int quiet_cycles;

  sorted_table_binary_search_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_entry_index   (in_entry_index),
    .in_value         (in_value),
    .in_search_mode   (in_search_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_index (out_result_index),
    .out_found        (out_found)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver: out_stall follows one of several patterns, each held for a random window
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(8, 64);
    end
    stall_left = stall_left - 1;
    case (stall_style)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall <= ($urandom_range(0, 9) < 6);
      end
      default: begin
        // long stall runs
        out_stall <= ((stall_left % 16) < 10);
      end
    endcase
  end

  // result monitor, sampled at the rising edge before the block updates
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_result_index, out_found);
  end

  // watchdog: ends the run when no word moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word accepted for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, sb.owed_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // offer one word from a falling edge and return at the falling edge after it is taken
  task automatic send_word(logic act, logic [IDX_W-1:0] idx,
                           logic signed [ENTRY_WIDTH-1:0] val, logic mode);
    int gap;
    if (idle_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 20);
        if (gap > 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left = burst_left - 1;
    end
    in_valid       = 1'b1;
    in_action      = act;
    in_entry_index = idx;
    in_value       = val;
    in_search_mode = mode;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(act, idx, val, mode);
    if (act == ACT_WRITE) writes_sent++;
    else searches_sent++;
    @(negedge clk);
  endtask

  // drain every owed result, then give a trailing write time to settle
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // program both range registers; only called while the block is idle
  task automatic set_range(int first, int last);
    cfg_we    = 1'b1;
    cfg_index = CFG_SEARCH_FIRST;
    cfg_wdata = first[CFG_W-1:0];
    @(negedge clk);
    sb.set_reg(CFG_SEARCH_FIRST, first);
    cfg_index = CFG_SEARCH_LAST;
    cfg_wdata = last[CFG_W-1:0];
    @(negedge clk);
    sb.set_reg(CFG_SEARCH_LAST, last);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  // load entries lo_i..hi_i: dense with duplicates, wide, spanning the full range, or unsorted
  task automatic fill_region(int lo_i, int hi_i, int style);
    longint cur;
    longint step_max;
    int     n;
    n = hi_i - lo_i + 1;
    case (style)
      0: begin
        step_max = 2;
        cur      = longint'(int'($urandom));
      end
      1: begin
        step_max = 1 << 24;
        cur      = longint'(int'($urandom)) >>> 2;
      end
      default: begin
        step_max = (n > 1) ? (64'h1_0000_0000 / n) : 1;
        cur      = longint'(VAL_MIN);
      end
    endcase
    for (int i = lo_i; i <= hi_i; i++) begin
      if (style == 3) begin
        send_word(ACT_WRITE, i[IDX_W-1:0], $urandom, MODE_LOWER);
      end else begin
        if (style == 2 && i == hi_i && n > 1) cur = longint'(VAL_MAX);
        send_word(ACT_WRITE, i[IDX_W-1:0], cur[ENTRY_WIDTH-1:0], MODE_LOWER);
        cur = cur + longint'($urandom_range(0, int'(step_max)));
        if (cur > longint'(VAL_MAX)) cur = longint'(VAL_MAX);
      end
    end
  endtask

  // search target: a stored value, a neighbor of one, a random word or an extreme
  function automatic logic signed [ENTRY_WIDTH-1:0] pick_target(int lo_i, int hi_i);
    logic signed [ENTRY_WIDTH-1:0] stored;
    int                            pick;
    pick = $urandom_range(0, 9);
    if (lo_i <= hi_i) stored = sb.entries[$urandom_range(lo_i, hi_i)];
    else stored = int'($urandom);
    case (pick)
      0, 1, 2, 3: return stored;
      4:          return stored + 1;
      5:          return stored - 1;
      6, 7:       return int'($urandom);
      8:          return VAL_MIN;
      default:    return VAL_MAX;
    endcase
  endfunction

  // searches mixed with stray writes, mostly outside the loaded region
  task automatic search_burst(int lo_i, int hi_i, int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 4) == 0)
        send_word(ACT_WRITE, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom,
                  1'($urandom_range(0, 1)));
      else
        send_word(ACT_SEARCH, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                  pick_target(lo_i, hi_i), 1'($urandom_range(0, 1)));
      random_words++;
    end
  endtask

  initial begin
    int first;
    int last;
    int cat;
    int reg_hi;
    int count;
    sb             = new();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SEARCH_FIRST;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_action      = ACT_WRITE;
    in_entry_index = '0;
    in_value       = '0;
    in_search_mode = MODE_LOWER;
    idle_on        = 1'b1;
    burst_left     = 0;
    writes_sent    = 0;
    searches_sent  = 0;
    settings_used  = 0;
    random_words   = 0;

    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: small table holding both extremes and duplicate runs
    set_range(0, 8);
    send_word(ACT_WRITE, IDX_W'(0), VAL_MIN, MODE_LOWER);
    send_word(ACT_WRITE, IDX_W'(1), -7, MODE_LOWER);
    send_word(ACT_WRITE, IDX_W'(2), -7, MODE_LOWER);
    send_word(ACT_WRITE, IDX_W'(3), 0, MODE_LOWER);
    send_word(ACT_WRITE, IDX_W'(4), 3, MODE_LOWER);
    send_word(ACT_WRITE, IDX_W'(5), 3, MODE_LOWER);
    send_word(ACT_WRITE, IDX_W'(6), 100, MODE_LOWER);
    send_word(ACT_WRITE, IDX_W'(7), 2000, MODE_LOWER);
    send_word(ACT_WRITE, IDX_W'(8), VAL_MAX, MODE_LOWER);
    send_word(ACT_SEARCH, '0, VAL_MIN, MODE_LOWER);
    send_word(ACT_SEARCH, '0, VAL_MIN, MODE_FLOOR);
    send_word(ACT_SEARCH, '0, VAL_MAX, MODE_LOWER);   // insertion point at the upper bound
    send_word(ACT_SEARCH, '0, VAL_MAX, MODE_FLOOR);   // inclusive bound reaches the last entry
    send_word(ACT_SEARCH, '0, -7, MODE_LOWER);
    send_word(ACT_SEARCH, '0, 3, MODE_FLOOR);
    send_word(ACT_SEARCH, '0, 1, MODE_LOWER);         // miss between entries
    send_word(ACT_SEARCH, '0, 1, MODE_FLOOR);
    send_word(ACT_SEARCH, '0, 2001, MODE_LOWER);
    send_word(ACT_SEARCH, '0, 2001, MODE_FLOOR);
    send_word(ACT_SEARCH, '0, -6, MODE_FLOOR);
    send_word(ACT_SEARCH, '0, 150, MODE_LOWER);
    wait_idle();
    // single-entry range: floor mode still compares the one entry
    set_range(5, 5);
    send_word(ACT_SEARCH, '0, 3, MODE_FLOOR);
    send_word(ACT_SEARCH, '0, 3, MODE_LOWER);
    wait_idle();
    // inverted range: nothing probed, index stays at search_first
    set_range(6, 3);
    send_word(ACT_SEARCH, '0, 0, MODE_LOWER);
    send_word(ACT_SEARCH, '0, 0, MODE_FLOOR);
    wait_idle();

    // top region of the table in ascending order, then bounds at and beyond the table end
    set_range(TOP_BASE, LAST_MAX);
    idle_on = 1'b0;
    fill_region(TOP_BASE, TABLE_DEPTH - 1, 2);
    idle_on = 1'b1;
    search_burst(TOP_BASE, TABLE_DEPTH - 1, 40);
    wait_idle();
    set_range(TABLE_DEPTH - 1, LAST_MAX);
    search_burst(TABLE_DEPTH - 1, TABLE_DEPTH - 1, 8);
    wait_idle();
    set_range(TOP_BASE, TABLE_DEPTH - 1);
    search_burst(TOP_BASE, TABLE_DEPTH - 1, 12);
    wait_idle();

    // random phases: new range, fresh contents for the range, then searches
    while (random_words < RANDOM_WORDS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      cat     = $urandom_range(0, 9);
      case (cat)
        5: begin
          first = $urandom_range(0, TABLE_DEPTH - 1);
          last  = $urandom_range(0, first);
        end
        6: begin
          first = $urandom_range(TABLE_DEPTH - 20, TABLE_DEPTH - 1);
          last  = LAST_MAX;
        end
        7: begin
          first = 0;
          last  = $urandom_range(0, 20);
        end
        8: begin
          first = $urandom_range(TABLE_DEPTH - 24, TABLE_DEPTH - 1);
          last  = $urandom_range(first, LAST_MAX);
        end
        9: begin
          first = TOP_BASE;
          last  = LAST_MAX;
        end
        default: begin
          first = $urandom_range(0, TABLE_DEPTH - 1);
          last  = first + $urandom_range(1, 20);
          if (last > LAST_MAX) last = LAST_MAX;
        end
      endcase
      set_range(first, last);
      reg_hi = (last > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : last;
      // every entry that either mode could probe is loaded; the top region reuses old contents
      if (cat != 9 && first <= reg_hi) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: fill_region(first, reg_hi, 0);
          4, 5, 6:    fill_region(first, reg_hi, 1);
          7, 8:       fill_region(first, reg_hi, 2);
          default:    fill_region(first, reg_hi, 3);
        endcase
        random_words += reg_hi - first + 1;
      end
      count = (cat == 9) ? $urandom_range(4, 10) : $urandom_range(8, 30);
      search_burst(first, reg_hi, count);
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.owed_q.size() != 0) begin
      $error("%0d search results never arrived", sb.owed_q.size());
      sb.errors++;
    end
    $display("covered %0d table writes and %0d searches over %0d range settings",
             writes_sent, searches_sent, settings_used);
    $display("%0d result words compared, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
